[sv/brdm_pkg.sv]
package brdm_pkg;

  // Default sizes of the macro store and the profile ring.
  localparam int MACRO_DEPTH_DEF   = 32;
  localparam int PROFILE_COUNT_DEF = 3;

  // Reset values of the configuration registers.
  localparam logic [15:0] DEBOUNCE_RST = 16'd200;
  localparam logic [15:0] LONG_PRESS_RST = 16'd700;
  localparam logic [15:0] GAP_MAX_RST = 16'd2000;

  // Register indexes on the configuration port (byte address is 4 times the index).
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [1:0] REG_GAP_MAX = 2'd2;

  // Button numbers.
  localparam logic [2:0] BTN_VIEW = 3'd3;
  localparam logic [2:0] BTN_JOY = 3'd4;

  // Gap saturation value for recorded steps.
  localparam logic [15:0] GAP_SAT = 16'hFFFF;

  // Result kinds.
  localparam logic [1:0] KIND_FLIGHT = 2'd0;
  localparam logic [1:0] KIND_PROFILE = 2'd1;
  localparam logic [1:0] KIND_REC_START = 2'd2;
  localparam logic [1:0] KIND_REC_STOP = 2'd3;

  typedef struct packed {
    logic [2:0]  button;
    logic        released;
    logic [31:0] now_ms;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  command_id;
    logic [1:0]  profile;
    logic [15:0] delay_ms;
    logic        last;
  } out_beat_t;

  // One stored macro step.
  typedef struct packed {
    logic [1:0]  id;
    logic [15:0] gap;
  } step_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_COMMIT,
    ST_RPL_READ,
    ST_RPL_PUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic commit;
    logic rpl_start;
    logic put_step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic btn_valid;
    logic is_joy;
    logic released;
    logic pass;
    logic recording;
    logic macro_empty;
    logic rpl_last;
    logic out_free;
  } sts_t;

endpackage

[sv/brdm_ctrl.sv]
module brdm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  brdm_pkg::sts_t  sts,
  output brdm_pkg::cmd_t  cmd
);
  import brdm_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_next = ST_IDLE;
        if (sts.btn_valid) begin
          if (sts.is_joy) begin
            if (!sts.released || sts.pass) begin
              state_next = ST_COMMIT;
            end else if (!sts.recording && !sts.macro_empty) begin
              state_next = ST_RPL_READ;
            end
          end else if (!sts.released && sts.pass) begin
            state_next = ST_COMMIT;
          end
        end
      end
      ST_COMMIT: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      ST_RPL_READ: begin
        state_next = ST_RPL_PUT;
      end
      ST_RPL_PUT: begin
        if (sts.out_free && sts.rpl_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_item = in_valid;
      end
      ST_DECIDE: begin
        cmd.rpl_start = sts.btn_valid && sts.is_joy && sts.released && !sts.pass &&
                        !sts.recording && !sts.macro_empty;
      end
      ST_COMMIT: begin
        cmd.commit = sts.out_free;
      end
      ST_RPL_READ: begin
        cmd = '0;
      end
      ST_RPL_PUT: begin
        cmd.put_step = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

  // A replay only runs over a non-empty store while not recording.
  a_replay_legal: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RPL_PUT) |-> (!sts.recording && !sts.macro_empty))
    else $error("replay running while recording or with an empty store");

  // A step is only put out after its read cycle or after the previous step.
  a_replay_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RPL_PUT) |-> ($past(state) == ST_RPL_READ || $past(state) == ST_RPL_PUT))
    else $error("replay output without a preceding read");

  // Commands are mutually exclusive.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

endmodule

[sv/brdm_datapath.sv]
module brdm_datapath #(
  parameter int MACRO_DEPTH   = brdm_pkg::MACRO_DEPTH_DEF,
  parameter int PROFILE_COUNT = brdm_pkg::PROFILE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  brdm_pkg::in_beat_t  in_data,
  output brdm_pkg::out_beat_t out_data,
  output logic                out_valid,
  input  logic                out_stall,
  input  logic [15:0]         debounce_ms,
  input  logic [15:0]         hold_min_ms,
  input  logic [15:0]         replay_gap_max_ms,
  input  brdm_pkg::cmd_t      cmd,
  output brdm_pkg::sts_t      sts
);
  import brdm_pkg::*;

  localparam int IDX_W = (MACRO_DEPTH > 1) ? $clog2(MACRO_DEPTH) : 1;
  localparam int LEN_W = $clog2(MACRO_DEPTH + 1);
  localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(MACRO_DEPTH);
  localparam logic [2:0] PROF_CNT = 3'(PROFILE_COUNT);
  localparam logic [1:0] PROF_RST = 2'(1 % PROFILE_COUNT);

  // Latched input item.
  in_beat_t item;

  // Event state.
  logic [31:0]      last_accept_time [4];
  logic [1:0]       profile_index;
  logic             recording;
  logic [LEN_W-1:0] macro_length;
  logic [31:0]      record_last_time;
  logic [31:0]      joy_press_time;

  // Macro store and replay read side.
  step_t            macro_steps [MACRO_DEPTH];
  step_t            rd_step;
  logic [IDX_W-1:0] rpl_idx;
  logic [IDX_W-1:0] rd_addr;

  // Event decode and the shared time compare.
  logic        btn_valid;
  logic        is_joy;
  logic [31:0] ref_time;
  logic [15:0] thresh;
  logic [31:0] elapsed;
  logic        pass;
  logic [31:0] gap_full;
  logic [15:0] gap_sat;
  logic        store_ok;
  logic [1:0]  profile_next;
  logic        emits;
  logic        out_free;
  logic        out_load;
  out_beat_t   beat;
  logic [15:0] rpl_delay;
  logic        rpl_last;

  // Capture the accepted item.
  always_ff @(posedge clk) begin
    if (cmd.load_item) item <= in_data;
  end

  assign btn_valid = (item.button <= BTN_JOY);
  assign is_joy    = (item.button == BTN_JOY);
  assign ref_time  = is_joy ? joy_press_time : last_accept_time[item.button[1:0]];
  assign thresh    = is_joy ? hold_min_ms : debounce_ms;
  assign elapsed   = item.now_ms - ref_time;
  assign pass      = (elapsed >= {16'd0, thresh});

  // Recording gap, saturated to 16 bits.
  assign gap_full = item.now_ms - record_last_time;
  assign gap_sat  = (|gap_full[31:16]) ? GAP_SAT : gap_full[15:0];
  assign store_ok = recording && (macro_length < DEPTH_L);

  assign profile_next = ((3'(profile_index) + 3'd1) == PROF_CNT) ? 2'd0
                                                                  : profile_index + 2'd1;

  // Event state update on commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) last_accept_time[i] <= '0;
      profile_index    <= PROF_RST;
      recording        <= 1'b0;
      macro_length     <= '0;
      record_last_time <= '0;
      joy_press_time   <= '0;
    end else if (cmd.commit) begin
      if (is_joy) begin
        if (!item.released) begin
          joy_press_time <= item.now_ms;
        end else begin
          recording <= !recording;
          if (!recording) begin
            macro_length     <= '0;
            record_last_time <= item.now_ms;
          end
        end
      end else begin
        last_accept_time[item.button[1:0]] <= item.now_ms;
        if (item.button == BTN_VIEW) begin
          profile_index <= profile_next;
        end else if (store_ok) begin
          macro_length     <= macro_length + LEN_W'(1);
          record_last_time <= item.now_ms;
        end
      end
    end
  end

  // Replay index walks the store one step per delivered beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      rpl_idx <= '0;
    end else if (cmd.rpl_start) begin
      rpl_idx <= '0;
    end else if (cmd.put_step) begin
      rpl_idx <= rpl_idx + IDX_W'(1);
    end
  end

  // Read one entry ahead so that a step can go out every cycle while the output is not stalled.
  assign rd_addr  = cmd.put_step ? rpl_idx + IDX_W'(1) : rpl_idx;
  assign rpl_last = ((LEN_W'(rpl_idx) + LEN_W'(1)) == macro_length);

  // Macro store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.commit && !is_joy && item.button != BTN_VIEW && store_ok) begin
      macro_steps[macro_length[IDX_W-1:0]] <= '{id: item.button[1:0], gap: gap_sat};
    end
    rd_step <= macro_steps[rd_addr];
  end

  assign rpl_delay = (rd_step.gap > replay_gap_max_ms) ? replay_gap_max_ms : rd_step.gap;

  // Result beat for the current command.
  always_comb begin
    beat      = '0;
    beat.last = 1'b1;
    emits     = 1'b1;
    if (cmd.put_step) begin
      beat.kind       = KIND_FLIGHT;
      beat.command_id = rd_step.id;
      beat.delay_ms   = rpl_delay;
      beat.last       = rpl_last;
    end else if (is_joy) begin
      emits     = item.released;
      beat.kind = recording ? KIND_REC_STOP : KIND_REC_START;
    end else if (item.button == BTN_VIEW) begin
      beat.kind    = KIND_PROFILE;
      beat.profile = profile_next;
    end else begin
      beat.kind       = KIND_FLIGHT;
      beat.command_id = item.button[1:0];
    end
  end

  // Output register.
  assign out_free = !out_valid || !out_stall;
  assign out_load = cmd.put_step || (cmd.commit && emits);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data <= beat;
  end

  assign sts = '{btn_valid:   btn_valid,
                 is_joy:      is_joy,
                 released:    item.released,
                 pass:        pass,
                 recording:   recording,
                 macro_empty: (macro_length == '0),
                 rpl_last:    rpl_last,
                 out_free:    out_free};

  // A new beat never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("result beat overwritten while stalled");

  // The store fill never passes its depth.
  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    macro_length <= DEPTH_L)
    else $error("macro length beyond store depth");

  // Starting a recording leaves an empty store.
  a_rec_clears: assert property (@(posedge clk) disable iff (rst)
    $rose(recording) |-> (macro_length == '0))
    else $error("recording started with a non-empty store");

  // The profile stays inside its ring.
  a_profile_bound: assert property (@(posedge clk) disable iff (rst)
    3'(profile_index) < PROF_CNT)
    else $error("profile index out of range");

endmodule

[sv/button_debounce_macro_recorder.sv]
// Button event processor with per-button debounce and a macro recorder. Each
// input beat is one button edge; a flight or view press yields one result beat,
// a long joystick hold toggles recording on release, and a short joystick click
// replays the stored macro as one beat per step, the last one marked by last.
// The block takes one event at a time. An event that is ignored or rejected
// returns to accepting from the decide state, a joystick press or an event that
// gives a single result from the commit state once the output register is free,
// and a replay from its put state after a read state; the replay pace of one
// step per cycle while the output is not stalled is set by the single read port
// of the macro store, which is read one entry ahead of the output register. A
// result waiting in the output register does not hold off the next input beat.
// Configuration registers sit at byte addresses 0 (debounce), 4 (long press) and
// 8 (replay gap clamp) and should only be written while the block is idle.
module button_debounce_macro_recorder #(
  parameter int MACRO_DEPTH   = brdm_pkg::MACRO_DEPTH_DEF,
  parameter int PROFILE_COUNT = brdm_pkg::PROFILE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  brdm_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output brdm_pkg::out_beat_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import brdm_pkg::*;

  logic [15:0] debounce_ms;
  logic [15:0] hold_min_ms;
  logic [15:0] replay_gap_max_ms;
  logic [1:0]  reg_idx;
  logic        cfg_write;
  cmd_t        cmd;
  sts_t        sts;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms       <= DEBOUNCE_RST;
      hold_min_ms       <= LONG_PRESS_RST;
      replay_gap_max_ms <= GAP_MAX_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_DEBOUNCE:   debounce_ms       <= pwdata[15:0];
        REG_LONG_PRESS: hold_min_ms       <= pwdata[15:0];
        REG_GAP_MAX:    replay_gap_max_ms <= pwdata[15:0];
        default:        ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      REG_DEBOUNCE:   prdata = {16'd0, debounce_ms};
      REG_LONG_PRESS: prdata = {16'd0, hold_min_ms};
      REG_GAP_MAX:    prdata = {16'd0, replay_gap_max_ms};
      default:        prdata = '0;
    endcase
  end

  brdm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  brdm_datapath #(
    .MACRO_DEPTH   (MACRO_DEPTH),
    .PROFILE_COUNT (PROFILE_COUNT)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .in_data           (in_data),
    .out_data          (out_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .debounce_ms       (debounce_ms),
    .hold_min_ms       (hold_min_ms),
    .replay_gap_max_ms (replay_gap_max_ms),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule
